/* design/atbl_pkg.sv */
`default_nettype none

package atbl_pkg;

    // fixed formats
    localparam int RATE_W       = 32;
    localparam int FACTOR_W     = 16;
    localparam int FACTOR_FRAC  = 14;
    localparam int LIMIT_W      = 8;
    localparam int STREAK_W     = 8;
    localparam int TOKEN_W      = 34;
    localparam int FRAC_BITS    = 16;
    localparam int MODE_W       = 3;
    localparam int STATUS_W     = 10;
    localparam int WINDOW_W     = 32;
    localparam int OUT_CNT_W    = 32;
    localparam int CFG_INDEX_W  = 3;

    localparam int COUNTER_BITS_DEF = 32;

    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 144;

    // one whole token in bucket units
    localparam logic [TOKEN_W-1:0] TOKEN_ONE = TOKEN_W'(1) << FRAC_BITS;

    // modes
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ACQUIRE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RESPONSE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_RATE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESTART  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_THROTTLED = 10'd429;
    localparam logic [STATUS_W-1:0] STATUS_OK_LOW    = 10'd200;
    localparam logic [STATUS_W-1:0] STATUS_OK_END    = 10'd400;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_RATE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RATE       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_FACTOR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEEDUP_FACTOR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_LIMIT = 3'd5;

    // register reset values
    localparam logic [RATE_W-1:0]   INITIAL_RATE_RST   = 32'd655360;
    localparam logic [RATE_W-1:0]   MIN_RATE_RST       = 32'd6554;
    localparam logic [RATE_W-1:0]   MAX_RATE_RST       = 32'd6553600;
    localparam logic [FACTOR_W-1:0] BACKOFF_FACTOR_RST = 16'd8192;
    localparam logic [FACTOR_W-1:0] SPEEDUP_FACTOR_RST = 16'd18022;
    localparam logic [LIMIT_W-1:0]  THROTTLE_LIMIT_RST = 8'd5;

    typedef struct packed {
        logic [RATE_W-1:0]   initial_rate;
        logic [RATE_W-1:0]   min_rate;
        logic [RATE_W-1:0]   max_rate;
        logic [FACTOR_W-1:0] backoff_factor;
        logic [FACTOR_W-1:0] speedup_factor;
        logic [LIMIT_W-1:0]  throttle_limit;
    } cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [STATUS_W-1:0] http_status;
        logic [WINDOW_W-1:0] window_limit;
        logic [WINDOW_W-1:0] window_remaining;
        logic [RATE_W-1:0]   new_rate;
    } item_t;

    typedef struct packed {
        logic [TOKEN_W-1:0]  tokens;
        logic [RATE_W-1:0]   rate;
        logic [STREAK_W-1:0] streak;
    } bucket_t;

    // what a word does to the response counters
    typedef struct packed {
        logic clear;
        logic response;
        logic success;
        logic throttle;
    } count_evt_t;

endpackage

`default_nettype wire

/* design/atbl_update.sv */
`default_nettype none

module atbl_update (
    input  atbl_pkg::cfg_t       cfg,
    input  atbl_pkg::item_t      item,
    input  atbl_pkg::bucket_t    cur,
    output atbl_pkg::bucket_t    nxt,
    output logic                 granted,
    output atbl_pkg::count_evt_t evt
);

    localparam int PROD_W = atbl_pkg::RATE_W + atbl_pkg::FACTOR_W;
    localparam int SUM_W  = atbl_pkg::TOKEN_W + 1;
    localparam int CAP_W  = atbl_pkg::RATE_W + 1;
    localparam int STREAK_MAX = (1 << atbl_pkg::STREAK_W) - 1;

    logic                              is_throttle;
    logic                              is_success;
    logic [atbl_pkg::FACTOR_W-1:0]     factor;
    logic [PROD_W-1:0]                 prod;
    logic                              prod_ovf;
    logic [atbl_pkg::RATE_W-1:0]       scaled;
    logic [SUM_W-1:0]                  fill_sum;
    logic [CAP_W-1:0]                  fill_cap;
    logic [atbl_pkg::STREAK_W-1:0]     streak_inc;
    logic                              spare;

    assign is_throttle = (item.http_status == atbl_pkg::STATUS_THROTTLED);
    assign is_success  = (item.http_status >= atbl_pkg::STATUS_OK_LOW) &&
                         (item.http_status <  atbl_pkg::STATUS_OK_END);

    // one multiplier, shared by backoff and speedup
    assign factor   = is_throttle ? cfg.backoff_factor : cfg.speedup_factor;
    assign prod     = PROD_W'(cur.rate) * PROD_W'(factor);
    assign prod_ovf = |prod[PROD_W-1:atbl_pkg::RATE_W+atbl_pkg::FACTOR_FRAC];
    assign scaled   = prod_ovf ? '1 :
        prod[atbl_pkg::RATE_W+atbl_pkg::FACTOR_FRAC-1:atbl_pkg::FACTOR_FRAC];

    assign fill_sum = SUM_W'(cur.tokens) + SUM_W'(cur.rate);
    assign fill_cap = {cur.rate, 1'b0};

    assign streak_inc = (cur.streak == atbl_pkg::STREAK_W'(STREAK_MAX)) ?
                        cur.streak : cur.streak + 1'b1;

    // more than half the window left
    assign spare = (item.window_limit != '0) && (item.window_remaining != '0) &&
                   ({item.window_remaining, 1'b0} > CAP_W'(item.window_limit));

    always_comb
    begin
        nxt     = cur;
        granted = 1'b0;
        evt     = '0;
        unique case (item.mode)
            atbl_pkg::MODE_TICK:
            begin
                nxt.tokens = (fill_sum > SUM_W'(fill_cap)) ?
                             atbl_pkg::TOKEN_W'(fill_cap) : fill_sum[atbl_pkg::TOKEN_W-1:0];
            end
            atbl_pkg::MODE_ACQUIRE:
            begin
                if (cur.tokens >= atbl_pkg::TOKEN_ONE)
                begin
                    nxt.tokens = cur.tokens - atbl_pkg::TOKEN_ONE;
                    granted    = 1'b1;
                end
            end
            atbl_pkg::MODE_RESPONSE:
            begin
                evt.response = 1'b1;
                if (is_throttle)
                begin
                    evt.throttle = 1'b1;
                    if (streak_inc >= cfg.throttle_limit)
                    begin
                        // give up: straight to the floor
                        nxt.rate   = cfg.min_rate;
                        nxt.streak = '0;
                    end
                    else
                    begin
                        nxt.streak = streak_inc;
                        nxt.rate   = (scaled < cfg.min_rate) ? cfg.min_rate : scaled;
                    end
                end
                else if (is_success)
                begin
                    evt.success = 1'b1;
                    nxt.streak  = '0;
                    if (spare)
                        nxt.rate = (scaled > cfg.max_rate) ? cfg.max_rate : scaled;
                end
            end
            atbl_pkg::MODE_SET_RATE:
            begin
                if (item.new_rate < cfg.min_rate)
                    nxt.rate = cfg.min_rate;
                else if (item.new_rate > cfg.max_rate)
                    nxt.rate = cfg.max_rate;
                else
                    nxt.rate = item.new_rate;
            end
            atbl_pkg::MODE_RESTART:
            begin
                nxt.tokens = '0;
                nxt.rate   = cfg.initial_rate;
                nxt.streak = '0;
                evt.clear  = 1'b1;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/adaptive_token_bucket_limiter.sv */
`default_nettype none

// Token bucket rate limiter whose fill rate (Q16.16 tokens per tick) follows
// server responses: a 429 scales the rate down by the backoff factor, a run of
// throttle_limit throttles drops it to min_rate, and a 2xx/3xx with more than
// half the window left scales it up by the speedup factor. One word on the
// slave side gives exactly one word on the master side. A word is registered
// on entry and its result in the state registers; the block takes one word per
// cycle as long as results are taken, limited by the bucket update loop (one
// 32x16 multiply plus clamp) that every word passes through. The user writes
// configuration only while no word is in flight; the block does not enforce it.
module adaptive_token_bucket_limiter #(
    parameter int COUNTER_BITS = atbl_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [atbl_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [atbl_pkg::RATE_W-1:0]       cfg_data,
    // slave side
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // http_status, window_limit, window_remaining, new_rate, zero pad
    input  wire logic [atbl_pkg::IN_DATA_W-1:0]    s_tdata,
    // mode
    input  wire logic [atbl_pkg::IN_USER_W-1:0]    s_tuser,
    // master side
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // granted, current_rate, throttle_streak, success_count,
    // throttled_count, response_count, zero pad
    output logic [atbl_pkg::OUT_DATA_W-1:0]        m_tdata
);

    localparam int EXT_W = 64;

    atbl_pkg::cfg_t       cfg_reg;
    atbl_pkg::item_t      item_reg;
    logic                 item_vld_reg;
    atbl_pkg::bucket_t    bucket_reg;
    atbl_pkg::bucket_t    bucket_next;
    logic                 out_vld_reg;
    logic                 granted_reg;
    logic                 granted_next;
    atbl_pkg::count_evt_t evt;
    logic [COUNTER_BITS-1:0] successes_reg;
    logic [COUNTER_BITS-1:0] throttles_reg;
    logic [COUNTER_BITS-1:0] responses_reg;
    logic                 advance;
    logic [EXT_W-1:0]     successes_ext;
    logic [EXT_W-1:0]     throttles_ext;
    logic [EXT_W-1:0]     responses_ext;

    // the state registers double as the result register: they move only
    // when a result is loaded
    assign advance  = item_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !item_vld_reg || advance;
    assign m_tvalid = out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_rate   <= atbl_pkg::INITIAL_RATE_RST;
            cfg_reg.min_rate       <= atbl_pkg::MIN_RATE_RST;
            cfg_reg.max_rate       <= atbl_pkg::MAX_RATE_RST;
            cfg_reg.backoff_factor <= atbl_pkg::BACKOFF_FACTOR_RST;
            cfg_reg.speedup_factor <= atbl_pkg::SPEEDUP_FACTOR_RST;
            cfg_reg.throttle_limit <= atbl_pkg::THROTTLE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                atbl_pkg::REG_INITIAL_RATE:   cfg_reg.initial_rate   <= cfg_data;
                atbl_pkg::REG_MIN_RATE:       cfg_reg.min_rate       <= cfg_data;
                atbl_pkg::REG_MAX_RATE:       cfg_reg.max_rate       <= cfg_data;
                atbl_pkg::REG_BACKOFF_FACTOR:
                    cfg_reg.backoff_factor <= cfg_data[atbl_pkg::FACTOR_W-1:0];
                atbl_pkg::REG_SPEEDUP_FACTOR:
                    cfg_reg.speedup_factor <= cfg_data[atbl_pkg::FACTOR_W-1:0];
                atbl_pkg::REG_THROTTLE_LIMIT:
                    cfg_reg.throttle_limit <= cfg_data[atbl_pkg::LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else if (s_tready)
            item_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.mode             <= s_tuser;
            item_reg.http_status      <= s_tdata[9:0];
            item_reg.window_limit     <= s_tdata[41:10];
            item_reg.window_remaining <= s_tdata[73:42];
            item_reg.new_rate         <= s_tdata[105:74];
        end
    end

    atbl_update u_update (
        .cfg     (cfg_reg),
        .item    (item_reg),
        .cur     (bucket_reg),
        .nxt     (bucket_next),
        .granted (granted_next),
        .evt     (evt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_reg.tokens <= '0;
            bucket_reg.rate   <= atbl_pkg::INITIAL_RATE_RST;
            bucket_reg.streak <= '0;
            successes_reg     <= '0;
            throttles_reg     <= '0;
            responses_reg     <= '0;
            granted_reg       <= 1'b0;
            out_vld_reg       <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                bucket_reg  <= bucket_next;
                granted_reg <= granted_next;
                if (evt.clear)
                begin
                    successes_reg <= '0;
                    throttles_reg <= '0;
                    responses_reg <= '0;
                end
                else
                begin
                    // saturating counters
                    if (evt.success && (successes_reg != '1))
                        successes_reg <= successes_reg + 1'b1;
                    if (evt.throttle && (throttles_reg != '1))
                        throttles_reg <= throttles_reg + 1'b1;
                    if (evt.response && (responses_reg != '1))
                        responses_reg <= responses_reg + 1'b1;
                end
            end
            if (advance)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    assign successes_ext = EXT_W'(successes_reg);
    assign throttles_ext = EXT_W'(throttles_reg);
    assign responses_ext = EXT_W'(responses_reg);

    assign m_tdata = {7'd0,
                      responses_ext[atbl_pkg::OUT_CNT_W-1:0],
                      throttles_ext[atbl_pkg::OUT_CNT_W-1:0],
                      successes_ext[atbl_pkg::OUT_CNT_W-1:0],
                      bucket_reg.streak,
                      bucket_reg.rate,
                      granted_reg};

    // every response that succeeds or is throttled is also counted as a response
    a_resp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (responses_reg >= successes_reg) && (responses_reg >= throttles_reg))
        else $error("response count below success or throttle count");

    // a grant only ever comes from an acquire word
    a_grant_mode: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (item_reg.mode != atbl_pkg::MODE_ACQUIRE) |=> !granted_reg)
        else $error("grant from a word that is not an acquire");

    // a processed word always leaves a result waiting
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed word without a result");

endmodule

`default_nettype wire
